@@ rtl/core/rlst_pkg.sv @@
// Shared types and constants for the run-length segment table.
// Used by every file of the block but rlst_ram; depends on nothing.
`default_nettype none

package rlst_pkg;

  localparam int OP_W    = 2;
  localparam int WHEN_W  = 14;
  localparam int LEVEL_W = 16;
  localparam int DUR_W   = 8;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  // Walk stops once the running sum reaches the offset, so it never passes
  // the largest offset plus one duration.
  localparam int SUM_W   = 15;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_INVERT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_PLAN,
    S_SHIFT,
    S_PUT_NEW,
    S_PUT_TAIL,
    S_PUT_HOST,
    S_INVERT,
    S_READ,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   duration;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic clear_cnt;
    logic walk_step;
    logic plan;
    logic shift_start;
    logic shift_step;
    logic put_new;
    logic put_tail;
    logic put_host;
    logic inv_step;
    logic read_load;
    logic set_fail;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  in_op;
    logic walk_done;
    logic walk_end;
    logic no_room;
    logic shift_needed;
    logic shift_last;
    logic split;
    logic inv_last;
    logic cnt_zero;
    logic read_hit;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/rlst_channels.sv @@
// Valid/ready channel interfaces for the run-length segment table.
// Depends on rlst_pkg for field widths.
`default_nettype none

interface rlst_item_if;
  logic                        valid;
  logic                        ready;
  logic [rlst_pkg::OP_W-1:0]    operation;
  logic [rlst_pkg::WHEN_W-1:0]  when;
  logic [rlst_pkg::LEVEL_W-1:0] new_level;
  logic [rlst_pkg::DUR_W-1:0]   new_duration;
  logic [rlst_pkg::IDX_W-1:0]   segment_index;

  modport source (output valid, operation, when, new_level, new_duration, segment_index,
                  input ready);
  modport sink   (input valid, operation, when, new_level, new_duration, segment_index,
                  output ready);
endinterface

interface rlst_result_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [rlst_pkg::LEVEL_W-1:0] read_level;
  logic [rlst_pkg::DUR_W-1:0]   read_duration;
  logic [rlst_pkg::COUNT_W-1:0] segment_count;

  modport source (output valid, status, read_level, read_duration, segment_count,
                  input ready);
  modport sink   (input valid, status, read_level, read_duration, segment_count,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/rlst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/rlst_ctrl.sv @@
// Controller state machine of the run-length segment table.
// Depends on rlst_pkg (state, command and status types).
`default_nettype none

module rlst_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire rlst_pkg::sts_t sts,
  output rlst_pkg::cmd_t      cmd
);

  rlst_pkg::state_t state;
  rlst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rlst_pkg::S_IDLE: begin
        if (item_valid) begin
          case (sts.in_op)
            rlst_pkg::OP_INSERT: state_next = rlst_pkg::S_WALK;
            rlst_pkg::OP_INVERT: state_next = sts.cnt_zero ? rlst_pkg::S_RESP
                                                           : rlst_pkg::S_INVERT;
            rlst_pkg::OP_READ:   state_next = rlst_pkg::S_READ;
            default:             state_next = rlst_pkg::S_RESP;
          endcase
        end
      end
      rlst_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_next = rlst_pkg::S_PLAN;
        end else if (sts.walk_end) begin
          state_next = rlst_pkg::S_RESP;
        end
      end
      rlst_pkg::S_PLAN: begin
        if (sts.no_room) begin
          state_next = rlst_pkg::S_RESP;
        end else if (sts.shift_needed) begin
          state_next = rlst_pkg::S_SHIFT;
        end else begin
          state_next = rlst_pkg::S_PUT_NEW;
        end
      end
      rlst_pkg::S_SHIFT: begin
        if (sts.shift_last) begin
          state_next = rlst_pkg::S_PUT_NEW;
        end
      end
      rlst_pkg::S_PUT_NEW: begin
        state_next = sts.split ? rlst_pkg::S_PUT_TAIL : rlst_pkg::S_RESP;
      end
      rlst_pkg::S_PUT_TAIL: state_next = rlst_pkg::S_PUT_HOST;
      rlst_pkg::S_PUT_HOST: state_next = rlst_pkg::S_RESP;
      rlst_pkg::S_INVERT: begin
        if (sts.inv_last) begin
          state_next = rlst_pkg::S_RESP;
        end
      end
      rlst_pkg::S_READ: state_next = rlst_pkg::S_RESP;
      rlst_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          state_next = rlst_pkg::S_IDLE;
        end
      end
      default: state_next = rlst_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      rlst_pkg::S_IDLE: begin
        item_ready    = 1'b1;
        cmd.accept    = item_valid;
        cmd.clear_cnt = item_valid && (sts.in_op == rlst_pkg::OP_CLEAR);
      end
      rlst_pkg::S_WALK: begin
        cmd.walk_step = !sts.walk_done && !sts.walk_end;
        cmd.set_fail  = !sts.walk_done && sts.walk_end;
      end
      rlst_pkg::S_PLAN: begin
        cmd.plan        = 1'b1;
        cmd.set_fail    = sts.no_room;
        cmd.shift_start = !sts.no_room && sts.shift_needed;
      end
      rlst_pkg::S_SHIFT:    cmd.shift_step = 1'b1;
      rlst_pkg::S_PUT_NEW:  cmd.put_new    = 1'b1;
      rlst_pkg::S_PUT_TAIL: cmd.put_tail   = 1'b1;
      rlst_pkg::S_PUT_HOST: cmd.put_host   = 1'b1;
      rlst_pkg::S_INVERT:   cmd.inv_step   = 1'b1;
      rlst_pkg::S_READ: begin
        cmd.read_load = sts.read_hit;
        cmd.set_fail  = !sts.read_hit;
      end
      rlst_pkg::S_RESP:     cmd.load_out   = !sts.out_busy;
      default: begin
        cmd        = '0;
        item_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != rlst_pkg::S_IDLE)
    else $error("accepted transaction did not start work");

  a_host_after_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.put_host |-> $past(cmd.put_tail))
    else $error("host rewrite without tail write");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rlst_dpath.sv @@
// Datapath of the run-length segment table: segment RAM, walk and shift
// pointer, running sum, segment count and output register.
// Depends on rlst_pkg and rlst_ram.
`default_nettype none

module rlst_dpath #(
  parameter int SEGMENTS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rlst_pkg::cmd_t                  cmd,
  output rlst_pkg::sts_t                       sts,
  input  wire logic [rlst_pkg::OP_W-1:0]       operation,
  input  wire logic [rlst_pkg::WHEN_W-1:0]     when,
  input  wire logic [rlst_pkg::LEVEL_W-1:0]    new_level,
  input  wire logic [rlst_pkg::DUR_W-1:0]      new_duration,
  input  wire logic [rlst_pkg::IDX_W-1:0]      segment_index,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output logic                                 status,
  output logic      [rlst_pkg::LEVEL_W-1:0]    read_level,
  output logic      [rlst_pkg::DUR_W-1:0]      read_duration,
  output logic      [rlst_pkg::COUNT_W-1:0]    segment_count
);

  localparam int AW = $clog2(SEGMENTS);
  localparam int PW = $clog2(SEGMENTS + 1);
  localparam int RW = (PW > rlst_pkg::IDX_W) ? PW : rlst_pkg::IDX_W;

  // latched transaction
  logic [rlst_pkg::WHEN_W-1:0]  when_r;
  logic [rlst_pkg::LEVEL_W-1:0] level_r;
  logic [rlst_pkg::DUR_W-1:0]   dur_r;
  logic [rlst_pkg::IDX_W-1:0]   idx_r;

  logic [PW-1:0]                ptr;
  logic [PW-1:0]                ptr_next;
  logic [PW-1:0]                base;
  logic [PW-1:0]                cnt;
  logic [rlst_pkg::SUM_W-1:0]   sum;
  logic [rlst_pkg::DUR_W-1:0]   delta;
  rlst_pkg::entry_t             host;

  logic                         res_status;
  logic [rlst_pkg::LEVEL_W-1:0] res_level;
  logic [rlst_pkg::DUR_W-1:0]   res_dur;

  rlst_pkg::entry_t             rd_entry;
  rlst_pkg::entry_t             wr_entry;
  logic                         we;
  logic [PW-1:0]                wr_addr;

  logic [rlst_pkg::SUM_W-1:0]   sum_diff;
  logic [rlst_pkg::DUR_W-1:0]   delta_c;
  logic [PW:0]                  gap_c;
  logic [PW-1:0]                gap;
  logic                         split;

  logic [$bits(rlst_pkg::entry_t)-1:0] ram_rdata;

  rlst_ram #(
    .WIDTH ($bits(rlst_pkg::entry_t)),
    .DEPTH (SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr[AW-1:0]),
    .wdata (wr_entry),
    .raddr (ptr_next[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // insert planning
  assign sum_diff = sum - rlst_pkg::SUM_W'(when_r);
  assign delta_c  = sum_diff[rlst_pkg::DUR_W-1:0];
  assign gap_c    = (delta_c != '0) ? (PW+1)'(2) : (PW+1)'(1);
  assign split    = (delta != '0);
  assign gap      = split ? PW'(2) : PW'(1);

  always_comb begin
    sts              = '0;
    sts.in_op        = rlst_pkg::op_t'(operation);
    sts.walk_done    = (sum >= rlst_pkg::SUM_W'(when_r));
    sts.walk_end     = (ptr >= cnt);
    sts.no_room      = (({1'b0, cnt} + gap_c) > (PW+1)'(SEGMENTS));
    sts.shift_needed = (cnt > ptr);
    sts.shift_last   = (ptr == base);
    sts.split        = split;
    sts.inv_last     = ((ptr + PW'(1)) == cnt);
    sts.cnt_zero     = (cnt == '0);
    sts.read_hit     = (RW'(idx_r) < RW'(cnt));
    sts.out_busy     = res_valid && !res_ready;
  end

  // read pointer; the RAM address is its next value
  always_comb begin
    ptr_next = ptr;
    if (cmd.accept) begin
      ptr_next = (rlst_pkg::op_t'(operation) == rlst_pkg::OP_READ) ? PW'(segment_index)
                                                                   : '0;
    end else if (cmd.walk_step || cmd.inv_step) begin
      ptr_next = ptr + PW'(1);
    end else if (cmd.shift_start) begin
      ptr_next = cnt - PW'(1);
    end else if (cmd.shift_step) begin
      ptr_next = ptr - PW'(1);
    end
  end

  // write port
  always_comb begin
    we       = 1'b0;
    wr_addr  = '0;
    wr_entry = '0;
    if (cmd.shift_step) begin
      we       = 1'b1;
      wr_addr  = ptr + gap;
      wr_entry = rd_entry;
    end else if (cmd.put_new) begin
      we                = 1'b1;
      wr_addr           = base;
      wr_entry.level    = level_r;
      wr_entry.duration = dur_r;
    end else if (cmd.put_tail) begin
      we                = 1'b1;
      wr_addr           = base + PW'(1);
      wr_entry.level    = host.level;
      wr_entry.duration = delta;
    end else if (cmd.put_host) begin
      we                = 1'b1;
      wr_addr           = base - PW'(1);
      wr_entry.level    = host.level;
      wr_entry.duration = host.duration - delta;
    end else if (cmd.inv_step) begin
      we                = 1'b1;
      wr_addr           = ptr;
      wr_entry.level    = (rd_entry.level == '0) ? rlst_pkg::LEVEL_W'(1) : '0;
      wr_entry.duration = rd_entry.duration;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clear_cnt) begin
        cnt <= '0;
      end else if (cmd.put_new && !split) begin
        cnt <= cnt + PW'(1);
      end else if (cmd.put_host) begin
        cnt <= cnt + PW'(2);
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.accept) begin
      when_r     <= when;
      level_r    <= new_level;
      dur_r      <= new_duration;
      idx_r      <= segment_index;
      sum        <= '0;
      res_status <= 1'b0;
      res_level  <= '0;
      res_dur    <= '0;
    end
    if (cmd.walk_step) begin
      sum  <= sum + rlst_pkg::SUM_W'(rd_entry.duration);
      host <= rd_entry;
    end
    if (cmd.plan) begin
      base  <= ptr;
      delta <= delta_c;
    end
    if (cmd.set_fail) begin
      res_status <= 1'b1;
    end
    if (cmd.read_load) begin
      res_level <= rd_entry.level;
      res_dur   <= rd_entry.duration;
    end
    if (cmd.load_out) begin
      status        <= res_status;
      read_level    <= res_level;
      read_duration <= res_dur;
      segment_count <= rlst_pkg::COUNT_W'(cnt);
    end
  end

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cnt} <= (PW+1)'(SEGMENTS))
    else $error("segment count above capacity");

  a_shift_moves_up: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> (wr_addr > ptr) && (ptr >= base))
    else $error("shift move outside the tail");
`endif

endmodule

`default_nettype wire

@@ rtl/core/run_length_segment_table.sv @@
// Top level of the run-length segment table: controller plus datapath.
// Depends on rlst_pkg, rlst_channels, rlst_ctrl, rlst_dpath (and rlst_ram).
`default_nettype none

// Keeps an ordered table of up to SEGMENTS waveform segments (16-bit level,
// 8-bit duration) in one single-port-write RAM, and answers one result
// transaction per item transaction. Insert walks the running sum of
// durations from the front, one entry per cycle, then moves the tail up by
// one or two places, one entry per cycle, then writes the new segment (and,
// for a split, the two halves of the host). A new item is taken only once the
// last one is done and its result is in the output register. The RAM does
// one read and one write per cycle. Offsets past the end and inserts with no
// room give status 1 and leave the table as it was; a read at or above the
// count gives status 1 and zero fields. The result sits in an output
// register, so the next item is taken while it waits; a new result waits in
// turn until that register is free. Table contents need no clearing after
// reset: only entries below the count are ever read.

module run_length_segment_table #(
  parameter int SEGMENTS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  rlst_item_if.sink    items,
  rlst_result_if.source results
);

  rlst_pkg::cmd_t cmd;
  rlst_pkg::sts_t sts;
  logic           item_ready;

  assign items.ready = item_ready;

  rlst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rlst_dpath #(
    .SEGMENTS (SEGMENTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (items.operation),
    .when          (items.when),
    .new_level     (items.new_level),
    .new_duration  (items.new_duration),
    .segment_index (items.segment_index),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .status        (results.status),
    .read_level    (results.read_level),
    .read_duration (results.read_duration),
    .segment_count (results.segment_count)
  );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for run_length_segment_table: directed and random transactions,
// with results checked against a behavioral copy of the segment table.
// Depends on rlst_pkg, rlst_channels and the block's RTL.

module testbench;
  import rlst_pkg::*;

  localparam int SEG             = 64;
  // Cycles with no transaction on either channel before we give up.
  // The limit leaves ample room for a slow insert plus random stalls.
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int SETTLE_CYCLES   = 150;

  // One expected result transaction.
  typedef struct packed {
    logic               status;
    logic [LEVEL_W-1:0] read_level;
    logic [DUR_W-1:0]   read_duration;
    logic [COUNT_W-1:0] segment_count;
  } result_t;

  // Behavioral segment table plus the queue of results it predicts.
  class segment_scoreboard;
    logic [LEVEL_W-1:0] lvl_tab[SEG];
    logic [DUR_W-1:0]   dur_tab[SEG];
    int unsigned        fill;
    result_t            pending[$];
    int                 errors;
    int                 n_items, n_results, n_insert, n_split, n_full, n_past_end, n_read;

    function new();
      fill = 0;
      errors = 0;
      n_items = 0;
      n_results = 0;
      n_insert = 0;
      n_split = 0;
      n_full = 0;
      n_past_end = 0;
      n_read = 0;
    endfunction

    // Total duration of the first k segments.
    function int unsigned span(int unsigned k);
      int unsigned i, sum;
      sum = 0;
      for (i = 0; i < k; i++) sum += dur_tab[i];
      return sum;
    endfunction

    // Move entries [from, fill) up by gap places; room already checked.
    function void open_gap(int unsigned from, int unsigned gap);
      int unsigned i;
      for (i = fill; i > from; i--) begin
        lvl_tab[i - 1 + gap] = lvl_tab[i - 1];
        dur_tab[i - 1 + gap] = dur_tab[i - 1];
      end
    endfunction

    // Insert at time offset 'at'; returns the status bit.
    function bit place(int unsigned at, logic [LEVEL_W-1:0] lv, logic [DUR_W-1:0] du);
      int unsigned i, sum, host, delta;
      i = 0;
      sum = 0;
      // stop at the first entry where the running sum reaches the offset
      while (sum < at) begin
        if (i >= fill) begin
          n_past_end++;
          return 1'b1;
        end
        sum += dur_tab[i];
        i++;
      end
      if (sum == 0) begin
        if (fill + 1 > SEG) begin
          n_full++;
          return 1'b1;
        end
        open_gap(0, 1);
        lvl_tab[0] = lv;
        dur_tab[0] = du;
        fill++;
        return 1'b0;
      end
      host = i - 1;
      delta = sum - at;
      if (delta != 0) begin
        // split: host keeps its start, new segment, then the host remainder
        if (fill + 2 > SEG) begin
          n_full++;
          return 1'b1;
        end
        open_gap(host + 1, 2);
        dur_tab[host]     = dur_tab[host] - DUR_W'(delta);
        lvl_tab[host + 1] = lv;
        dur_tab[host + 1] = du;
        lvl_tab[host + 2] = lvl_tab[host];
        dur_tab[host + 2] = DUR_W'(delta);
        fill += 2;
        n_split++;
      end else begin
        if (fill + 1 > SEG) begin
          n_full++;
          return 1'b1;
        end
        open_gap(host + 1, 1);
        lvl_tab[host + 1] = lv;
        dur_tab[host + 1] = du;
        fill++;
      end
      return 1'b0;
    endfunction

    // Accepted item transaction: update the table, queue the result it implies.
    function void note(op_t op, logic [WHEN_W-1:0] at, logic [LEVEL_W-1:0] lv,
                       logic [DUR_W-1:0] du, logic [IDX_W-1:0] idx);
      result_t     r;
      int unsigned i;
      r = '0;
      n_items++;
      case (op)
        OP_INSERT: begin
          n_insert++;
          r.status = place(at, lv, du);
        end
        OP_INVERT: begin
          for (i = 0; i < fill; i++) lvl_tab[i] = (lvl_tab[i] == '0) ? LEVEL_W'(1) : '0;
        end
        OP_READ: begin
          n_read++;
          if (idx < fill) begin
            r.read_level    = lvl_tab[idx];
            r.read_duration = dur_tab[idx];
          end else begin
            r.status = 1'b1;
          end
        end
        default: fill = 0;
      endcase
      r.segment_count = COUNT_W'(fill);
      pending.push_back(r);
    endfunction

    // Accepted result transaction: compare with the oldest expectation.
    function void check(logic st, logic [LEVEL_W-1:0] rl, logic [DUR_W-1:0] rd,
                        logic [COUNT_W-1:0] cnt);
      result_t want;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d level %0h duration %0d count %0d",
                 $time, st, rl, rd, cnt);
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (rl !== want.read_level) begin
        errors++;
        $display("%0t: read_level expected %0h actual %0h", $time, want.read_level, rl);
      end
      if (rd !== want.read_duration) begin
        errors++;
        $display("%0t: read_duration expected %0d actual %0d", $time, want.read_duration, rd);
      end
      if (cnt !== want.segment_count) begin
        errors++;
        $display("%0t: segment_count expected %0d actual %0d", $time, want.segment_count, cnt);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  rlst_item_if   items_ch ();
  rlst_result_if results_ch ();

  run_length_segment_table #(.SEGMENTS(SEG)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  segment_scoreboard sb;

  int src_idle_pct;
  int sink_idle_pct;
  int quiet_cycles;
  bit progress;

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: ready changes on the falling edge, stalling at the phase's rate.
  always @(negedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor: everything is sampled at the rising edge, before the block updates.
  // Item transactions go into the predictor first, then any result is checked.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (items_ch.valid && items_ch.ready) begin
        sb.note(op_t'(items_ch.operation), items_ch.when, items_ch.new_level,
                items_ch.new_duration, items_ch.segment_index);
        progress = 1'b1;
      end
      if (results_ch.valid && results_ch.ready) begin
        sb.check(results_ch.status, results_ch.read_level, results_ch.read_duration,
                 results_ch.segment_count);
        progress = 1'b1;
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Present one item and hold it until accepted. Entered and left just after a
  // falling edge, so valid gets a single assignment per time step.
  task automatic send(op_t op, logic [WHEN_W-1:0] at, logic [LEVEL_W-1:0] lv,
                      logic [DUR_W-1:0] du, logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < src_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid         <= 1'b1;
    items_ch.operation     <= op;
    items_ch.when          <= at;
    items_ch.new_level     <= lv;
    items_ch.new_duration  <= du;
    items_ch.segment_index <= idx;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    items_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Mostly inserts aimed at the current table (front, boundaries, splits, just
  // past the end), with reads, inverts and a rare clear so the table keeps
  // filling up to capacity and then emptying again.
  task automatic random_item();
    int unsigned       total, k, pick;
    op_t               op;
    logic [WHEN_W-1:0] at;
    logic [LEVEL_W-1:0] lv;
    logic [DUR_W-1:0]  du;
    logic [IDX_W-1:0]  idx;
    total = sb.span(sb.fill);
    pick  = $urandom_range(999);
    at    = WHEN_W'($urandom);
    lv    = LEVEL_W'($urandom);
    du    = DUR_W'($urandom);
    idx   = IDX_W'($urandom);
    if (pick < 15) begin
      op = OP_CLEAR;
    end else if (pick < 60) begin
      op = OP_INVERT;
    end else if (pick < 250) begin
      op = OP_READ;
      if ($urandom_range(3) != 0)
        idx = IDX_W'($urandom_range((sb.fill < SEG) ? sb.fill : SEG - 1));
    end else begin
      op = OP_INSERT;
      case ($urandom_range(9))
        0: at = '0;
        1, 2: begin
          k  = $urandom_range(sb.fill);
          at = WHEN_W'(sb.span(k));
        end
        3: at = WHEN_W'(total + $urandom_range(1, 20));
        9: ;  // fully random offset, usually far past the end
        default: at = WHEN_W'($urandom_range(total));
      endcase
      case ($urandom_range(7))
        0: du = '0;
        1: du = '1;
        default: ;
      endcase
      // 0/1 levels make inverts interesting
      if ($urandom_range(3) == 0) lv = LEVEL_W'($urandom_range(1));
    end
    send(op, at, lv, du, idx);
  endtask

  int src_pct[3]  = '{18, 47, 0};
  int sink_pct[3] = '{47, 18, 0};

  initial begin
    int phase, n, k;
    sb = new();
    rst = 1'b1;
    items_ch.valid         = 1'b0;
    items_ch.operation     = OP_INSERT;
    items_ch.when          = '0;
    items_ch.new_level     = '0;
    items_ch.new_duration  = '0;
    items_ch.segment_index = '0;
    results_ch.ready       = 1'b0;
    src_idle_pct  = src_pct[0];
    sink_idle_pct = sink_pct[0];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-table errors, front / boundary / split inserts, zero
    // durations, extreme field values, invert, read range, clear.
    send(OP_READ,   0,       16'h0000, 8'd0,   6'd0);   // read of empty table
    send(OP_INSERT, 1,       16'h1111, 8'd5,   6'd0);   // past end of empty table
    send(OP_INSERT, 0,       16'hFFFF, 8'd255, 6'd0);   // front
    send(OP_INSERT, 0,       16'h0000, 8'd0,   6'd0);   // zero duration at front
    send(OP_INSERT, 255,     16'h1234, 8'd10,  6'd0);   // boundary at the end
    send(OP_INSERT, 100,     16'hA5A5, 8'd1,   6'd0);   // split of the long segment
    send(OP_INSERT, 100,     16'h0007, 8'd0,   6'd0);   // boundary, zero duration
    send(OP_INSERT, 100,     16'h0008, 8'd5,   6'd0);   // lands ahead of the zero one
    send(OP_INSERT, 16383,   16'h5A5A, 8'd3,   6'd63);  // largest offset
    send(OP_INSERT, 272,     16'h00FF, 8'd2,   6'd0);   // one past the end
    for (k = 0; k < 8; k++) send(OP_READ, 0, 16'h0000, 8'd0, IDX_W'(k));
    send(OP_INVERT, 0,       16'h0000, 8'd0,   6'd0);
    send(OP_READ,   0,       16'h0000, 8'd0,   6'd1);
    send(OP_INVERT, 0,       16'h0000, 8'd0,   6'd0);
    send(OP_READ,   0,       16'h0000, 8'd0,   6'd63);  // index far out of range
    send(OP_CLEAR,  0,       16'h0000, 8'd0,   6'd0);
    send(OP_READ,   0,       16'h0000, 8'd0,   6'd0);
    send(OP_INVERT, 0,       16'h0000, 8'd0,   6'd0);   // invert on empty table

    // Random: three idling profiles, each with one full drain in the middle.
    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct  = src_pct[phase];
      sink_idle_pct = sink_pct[phase];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d item and %0d result transactions: %0d inserts, %0d splits",
             sb.n_items, sb.n_results, sb.n_insert, sb.n_split);
    $display("rejected %0d inserts on a full table and %0d past the end; %0d reads",
             sb.n_full, sb.n_past_end, sb.n_read);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
